>>> hdl/atq_pkg.sv
// Package for the affinity task queue: request and result types, microcode format and program.
`default_nettype none

package atq_pkg;

  // One request: push a task or pop for a worker.
  typedef struct packed {
    logic        cmd;
    logic [63:0] affinity_mask;
    logic [31:0] task_handle;
  } in_t;

  // One result.
  typedef struct packed {
    logic        popped;
    logic [31:0] popped_handle;
    logic        any_pending;
    logic        retrigger;
    logic        push_dropped;
  } out_t;

  // Request command codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Step counter width and step addresses of the program.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] S_DISP  = 4'd1;
  localparam logic [STEP_W-1:0] S_SCAN  = 4'd2;
  localparam logic [STEP_W-1:0] S_TEST  = 4'd3;
  localparam logic [STEP_W-1:0] S_ADV   = 4'd4;
  localparam logic [STEP_W-1:0] S_HIT   = 4'd5;
  localparam logic [STEP_W-1:0] S_SHRD  = 4'd6;
  localparam logic [STEP_W-1:0] S_SHWR  = 4'd7;
  localparam logic [STEP_W-1:0] S_HDONE = 4'd8;
  localparam logic [STEP_W-1:0] S_MISS  = 4'd9;
  localparam logic [STEP_W-1:0] S_PUSH  = 4'd10;
  localparam logic [STEP_W-1:0] S_PUSHW = 4'd11;
  localparam logic [STEP_W-1:0] S_DROP  = 4'd12;

  // Memory write select.
  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_PUSH  = 2'd1;
  localparam logic [1:0] WR_SHIFT = 2'd2;

  // Index register operation.
  localparam logic [1:0] IDX_HOLD = 2'd0;
  localparam logic [1:0] IDX_CLR  = 2'd1;
  localparam logic [1:0] IDX_INC  = 2'd2;

  // Entry count operation.
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;

  // Result produced by a step.
  localparam logic [2:0] RES_NONE = 3'd0;
  localparam logic [2:0] RES_PUSH = 3'd1;
  localparam logic [2:0] RES_DROP = 3'd2;
  localparam logic [2:0] RES_HIT  = 3'd3;
  localparam logic [2:0] RES_MISS = 3'd4;

  // Jump conditions; without a jump the step counter advances by one.
  localparam logic [2:0] JC_NEVER   = 3'd0;
  localparam logic [2:0] JC_ALWAYS  = 3'd1;
  localparam logic [2:0] JC_NOSTART = 3'd2;
  localparam logic [2:0] JC_PUSH    = 3'd3;
  localparam logic [2:0] JC_END     = 3'd4;
  localparam logic [2:0] JC_MATCH   = 3'd5;
  localparam logic [2:0] JC_FULL    = 3'd6;

  // One control word.
  typedef struct packed {
    logic              rd;
    logic              cap;
    logic [1:0]        wr;
    logic [1:0]        idx_op;
    logic [1:0]        cnt_op;
    logic [2:0]        res;
    logic [2:0]        jc;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Builds a control word from its fields.
  function automatic ctrl_t cw(input logic rd, input logic cap, input logic [1:0] wr,
                               input logic [1:0] idx_op, input logic [1:0] cnt_op,
                               input logic [2:0] res, input logic [2:0] jc,
                               input logic [STEP_W-1:0] target);
    ctrl_t w;
    w.rd     = rd;
    w.cap    = cap;
    w.wr     = wr;
    w.idx_op = idx_op;
    w.cnt_op = cnt_op;
    w.res    = res;
    w.jc     = jc;
    w.target = target;
    return w;
  endfunction

  // The program: push or drop, oldest-first scan, then compaction by moving later entries down.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    unique case (step)
      S_IDLE:  w = cw(1'b0, 1'b0, WR_NONE,  IDX_HOLD, CNT_HOLD, RES_NONE, JC_NOSTART, S_IDLE);
      S_DISP:  w = cw(1'b0, 1'b0, WR_NONE,  IDX_CLR,  CNT_HOLD, RES_NONE, JC_PUSH,    S_PUSH);
      S_SCAN:  w = cw(1'b1, 1'b0, WR_NONE,  IDX_HOLD, CNT_HOLD, RES_NONE, JC_END,     S_MISS);
      S_TEST:  w = cw(1'b0, 1'b0, WR_NONE,  IDX_HOLD, CNT_HOLD, RES_NONE, JC_MATCH,   S_HIT);
      S_ADV:   w = cw(1'b0, 1'b0, WR_NONE,  IDX_INC,  CNT_HOLD, RES_NONE, JC_ALWAYS,  S_SCAN);
      S_HIT:   w = cw(1'b0, 1'b1, WR_NONE,  IDX_INC,  CNT_HOLD, RES_NONE, JC_NEVER,   S_IDLE);
      S_SHRD:  w = cw(1'b1, 1'b0, WR_NONE,  IDX_HOLD, CNT_HOLD, RES_NONE, JC_END,     S_HDONE);
      S_SHWR:  w = cw(1'b0, 1'b0, WR_SHIFT, IDX_INC,  CNT_HOLD, RES_NONE, JC_ALWAYS,  S_SHRD);
      S_HDONE: w = cw(1'b0, 1'b0, WR_NONE,  IDX_HOLD, CNT_DEC,  RES_HIT,  JC_ALWAYS,  S_IDLE);
      S_MISS:  w = cw(1'b0, 1'b0, WR_NONE,  IDX_HOLD, CNT_HOLD, RES_MISS, JC_ALWAYS,  S_IDLE);
      S_PUSH:  w = cw(1'b0, 1'b0, WR_NONE,  IDX_HOLD, CNT_HOLD, RES_NONE, JC_FULL,    S_DROP);
      S_PUSHW: w = cw(1'b0, 1'b0, WR_PUSH,  IDX_HOLD, CNT_INC,  RES_PUSH, JC_ALWAYS,  S_IDLE);
      S_DROP:  w = cw(1'b0, 1'b0, WR_NONE,  IDX_HOLD, CNT_HOLD, RES_DROP, JC_ALWAYS,  S_IDLE);
      default: w = cw(1'b0, 1'b0, WR_NONE,  IDX_HOLD, CNT_HOLD, RES_NONE, JC_ALWAYS,  S_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hdl/affinity_task_queue.sv
// Affinity task queue: microcoded sequencer over a task memory with oldest-first matching.
// A push is dispatched, checked for a full store, then written or dropped. A pop reads and tests
// the stored tasks oldest first; a match is captured and every later task moved down, else a miss.
// One request at a time: busy drops in the result cycle, in which a new request can be accepted;
// the scan loop walks the store through its one read and one write port.
// Synchronous reset empties the store and returns the sequencer to idle; the results are
// shown for one cycle each and the receiver cannot stall them.
`default_nettype none

module affinity_task_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire atq_pkg::in_t  request,
  output logic               done,
  output atq_pkg::out_t      result
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int HW = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // Sequencer and datapath registers.
  logic [atq_pkg::STEP_W-1:0] upc;
  logic [atq_pkg::STEP_W-1:0] upc_next;
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic [CW-1:0]              idx;
  logic [CW-1:0]              idx_next;
  atq_pkg::in_t               req_q;
  logic [63:0]                rd_mask;
  logic [HW-1:0]              rd_handle;
  logic [HW-1:0]              got;
  atq_pkg::ctrl_t             ctl;
  atq_pkg::out_t              result_next;

  // Task memory.
  logic [63:0]   mem_mask   [QUEUE_DEPTH];
  logic [HW-1:0] mem_handle [QUEUE_DEPTH];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_mask;
  logic [HW-1:0] wr_handle;
  logic [CW-1:0] idx_m1;

  // Status seen by the jump logic.
  logic idx_end;
  logic full;
  logic match;
  logic jump;

  assign ctl     = atq_pkg::ucode(upc);
  assign busy    = (upc != atq_pkg::S_IDLE);
  assign idx_end = (idx == count);
  assign full    = (count == DEPTH_C);
  assign match   = (rd_mask == 64'd0) || ((rd_mask & req_q.affinity_mask) == rd_mask);
  assign idx_m1  = idx - CW'(1);

  // Jump decision and next step.
  always_comb begin
    unique case (ctl.jc)
      atq_pkg::JC_ALWAYS:  jump = 1'b1;
      atq_pkg::JC_NOSTART: jump = !start;
      atq_pkg::JC_PUSH:    jump = (req_q.cmd == atq_pkg::CMD_PUSH);
      atq_pkg::JC_END:     jump = idx_end;
      atq_pkg::JC_MATCH:   jump = match;
      atq_pkg::JC_FULL:    jump = full;
      default:             jump = 1'b0;
    endcase
    upc_next = jump ? ctl.target : (upc + atq_pkg::STEP_W'(1));
  end

  // Index and count updates.
  always_comb begin
    unique case (ctl.idx_op)
      atq_pkg::IDX_CLR: idx_next = '0;
      atq_pkg::IDX_INC: idx_next = idx + CW'(1);
      default:          idx_next = idx;
    endcase
    unique case (ctl.cnt_op)
      atq_pkg::CNT_INC: count_next = count + CW'(1);
      atq_pkg::CNT_DEC: count_next = count - CW'(1);
      default:          count_next = count;
    endcase
  end

  // Memory write port: append on push, move one entry down during compaction.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = count[AW-1:0];
    wr_mask   = req_q.affinity_mask;
    wr_handle = req_q.task_handle[HW-1:0];
    unique case (ctl.wr)
      atq_pkg::WR_PUSH: begin
        wr_en = 1'b1;
      end
      atq_pkg::WR_SHIFT: begin
        wr_en     = 1'b1;
        wr_addr   = idx_m1[AW-1:0];
        wr_mask   = rd_mask;
        wr_handle = rd_handle;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Result word for the step that reports.
  always_comb begin
    result_next = '0;
    unique case (ctl.res)
      atq_pkg::RES_DROP: begin
        result_next.push_dropped = 1'b1;
      end
      atq_pkg::RES_HIT: begin
        result_next.popped        = 1'b1;
        result_next.popped_handle = 32'(got);
        result_next.any_pending   = 1'b1;
      end
      atq_pkg::RES_MISS: begin
        result_next.any_pending = (count != '0);
        result_next.retrigger   = (count != '0);
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc   <= atq_pkg::S_IDLE;
      count <= '0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      upc   <= upc_next;
      count <= count_next;
      idx   <= idx_next;
      done  <= (ctl.res != atq_pkg::RES_NONE);
    end
  end

  // Payload registers: request latch, captured handle and result.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= request;
    end
    if (ctl.cap) begin
      got <= rd_handle;
    end
    if (ctl.res != atq_pkg::RES_NONE) begin
      result <= result_next;
    end
  end

  // Task memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_mask[wr_addr]   <= wr_mask;
      mem_handle[wr_addr] <= wr_handle;
    end
    if (ctl.rd) begin
      rd_mask   <= mem_mask[idx[AW-1:0]];
      rd_handle <= mem_handle[idx[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

>>> hdl/atq_checker.sv
// Port-level checker for the affinity task queue and its bind to the top level.
`default_nettype none

module atq_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire atq_pkg::in_t  request,
  input wire logic          done,
  input wire atq_pkg::out_t result
);

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // A result is only reported after the block was working on a request.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  // A removed task implies pending work and excludes the other flags.
  a_popped_flags: assert property (@(posedge clk) disable iff (rst)
    (done && result.popped) |-> (result.any_pending && !result.retrigger &&
                                 !result.push_dropped))
    else $error("inconsistent flags on a successful pop");

  // A retrigger means tasks were pending and nothing was removed.
  a_retrigger_flags: assert property (@(posedge clk) disable iff (rst)
    (done && result.retrigger) |-> (result.any_pending && !result.popped &&
                                    !result.push_dropped))
    else $error("inconsistent flags on a retrigger");

  // Without a removed task the handle reads zero.
  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.popped) |-> (result.popped_handle == 32'd0))
    else $error("nonzero handle without a pop");

endmodule

bind affinity_task_queue atq_checker u_atq_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);

`default_nettype wire

>>> test/affinity_task_queue_tb.sv
// Self-checking testbench for the affinity task queue: directed, full-store and random requests.
`timescale 1ns / 1ps

module affinity_task_queue_tb;

  localparam int STORE_DEPTH  = 16;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 1150;
  localparam logic [63:0] ALL_WORKERS = {64{1'b1}};

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  atq_pkg::in_t  request;
  atq_pkg::out_t result;

  // Shadow copy of the store, oldest task at index 0.
  logic [63:0] shadow_mask   [STORE_DEPTH];
  logic [31:0] shadow_handle [STORE_DEPTH];
  int          shadow_count;

  atq_pkg::out_t predicted_results[$];
  int   error_count;
  int   cycle_count;
  bit   burst_mode;

  affinity_task_queue dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Applies one request to the shadow store and returns the result it must produce.
  function automatic atq_pkg::out_t apply_to_shadow(input atq_pkg::in_t req);
    atq_pkg::out_t res;
    int   n;
    int   i;
    int   k;
    res = '0;
    n = shadow_count;
    if (req.cmd == atq_pkg::CMD_PUSH) begin
      if (n >= STORE_DEPTH) begin
        res.push_dropped = 1'b1;
      end else begin
        shadow_mask[n]   = req.affinity_mask;
        shadow_handle[n] = req.task_handle;
        shadow_count     = n + 1;
      end
    end else begin
      res.any_pending = (n > 0);
      for (i = 0; i < n; i++) begin
        if (!res.popped && (shadow_mask[i] == '0 ||
            (shadow_mask[i] & req.affinity_mask) == shadow_mask[i])) begin
          res.popped        = 1'b1;
          res.popped_handle = shadow_handle[i];
          for (k = i; k + 1 < n; k++) begin
            shadow_mask[k]   = shadow_mask[k + 1];
            shadow_handle[k] = shadow_handle[k + 1];
          end
          shadow_count = n - 1;
        end
      end
      res.retrigger = res.any_pending && !res.popped;
    end
    return res;
  endfunction

  // Presents one request and holds it until the block takes it.
  task automatic send_request(input logic cmd, input logic [63:0] mask,
                              input logic [31:0] handle);
    atq_pkg::in_t req;
    req.cmd           = cmd;
    req.affinity_mask = mask;
    req.task_handle   = handle;
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    predicted_results.push_back(apply_to_shadow(req));
  endtask

  // Drops start for a random number of cycles, mostly short, sometimes long, and not at all in burst mode.
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (burst_mode) n = 0;
    else if (r < 60) n = $urandom_range(0, 2);
    else if (r < 90) n = $urandom_range(3, 6);
    else n = $urandom_range(15, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_and_pause(input logic cmd, input logic [63:0] mask,
                                input logic [31:0] handle);
    send_request(cmd, mask, handle);
    idle_gap();
  endtask

  function automatic logic [63:0] random_word64();
    return {$urandom, $urandom};
  endfunction

  // Task masks: "any worker", one or two bits, dense, all workers or sparse.
  function automatic logic [63:0] random_task_mask();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 6) return (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
    if (r < 8) return random_word64();
    if (r == 8) return ALL_WORKERS;
    return random_word64() & random_word64() & random_word64();
  endfunction

  // Worker masks: often a superset of a stored task so that pops hit deep in the store.
  function automatic logic [63:0] random_worker_mask();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && shadow_count > 0)
      return shadow_mask[$urandom_range(0, shadow_count - 1)] |
             (random_word64() & random_word64());
    if (r == 4) return ALL_WORKERS;
    if (r == 5) return '0;
    return random_word64() | (64'd1 << $urandom_range(0, 63));
  endfunction

  // Compare every result with the oldest prediction.
  always @(posedge clk) begin
    atq_pkg::out_t want;
    if (!rst && done) begin
      if (predicted_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        error_count++;
      end else begin
        want = predicted_results.pop_front();
        if (result.popped !== want.popped) begin
          $error("popped: expected %0d, got %0d", want.popped, result.popped);
          error_count++;
        end
        if (result.popped_handle !== want.popped_handle) begin
          $error("popped_handle: expected %0h, got %0h", want.popped_handle,
                 result.popped_handle);
          error_count++;
        end
        if (result.any_pending !== want.any_pending) begin
          $error("any_pending: expected %0d, got %0d", want.any_pending, result.any_pending);
          error_count++;
        end
        if (result.retrigger !== want.retrigger) begin
          $error("retrigger: expected %0d, got %0d", want.retrigger, result.retrigger);
          error_count++;
        end
        if (result.push_dropped !== want.push_dropped) begin
          $error("push_dropped: expected %0d, got %0d", want.push_dropped,
                 result.push_dropped);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Empty store, "any worker" tasks, subset matching out of order and a miss.
  task automatic test_directed();
    send_and_pause(atq_pkg::CMD_POP, ALL_WORKERS, 32'hFFFF_FFFF);
    send_and_pause(atq_pkg::CMD_PUSH, 64'h0, 32'h0);
    send_and_pause(atq_pkg::CMD_PUSH, ALL_WORKERS, 32'hFFFF_FFFF);
    send_and_pause(atq_pkg::CMD_PUSH, 64'h8000_0000_0000_0001, 32'h1234_5678);
    send_and_pause(atq_pkg::CMD_PUSH, 64'h5555_5555_5555_5555, 32'hA5A5_5A5A);
    send_and_pause(atq_pkg::CMD_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0F0F_F0F0);
    // A zero worker mask only takes the task that any worker may run.
    send_and_pause(atq_pkg::CMD_POP, 64'h0, 32'h0);
    send_and_pause(atq_pkg::CMD_POP, 64'h0, 32'hFFFF_FFFF);
    send_and_pause(atq_pkg::CMD_POP, 64'h1, 32'h0);
    // The next two skip older tasks that need workers outside the mask.
    send_and_pause(atq_pkg::CMD_POP, 64'h8000_0000_0000_0001, 32'h0);
    send_and_pause(atq_pkg::CMD_POP, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0);
    send_and_pause(atq_pkg::CMD_POP, ALL_WORKERS, 32'h0);
    send_and_pause(atq_pkg::CMD_POP, 64'h5555_5555_5555_5555, 32'h0);
    send_and_pause(atq_pkg::CMD_POP, 64'h5555_5555_5555_5555, 32'h0);
  endtask

  // Fills the store, pushes into the full store, hits the newest task, misses all and drains the store.
  task automatic test_full_store();
    for (int i = 0; i < STORE_DEPTH; i++)
      send_and_pause(atq_pkg::CMD_PUSH, 64'd1 << i, $urandom);
    send_and_pause(atq_pkg::CMD_PUSH, 64'h0, $urandom);
    send_and_pause(atq_pkg::CMD_PUSH, random_word64(), $urandom);
    send_and_pause(atq_pkg::CMD_POP, 64'd1 << (STORE_DEPTH - 1), $urandom);
    send_and_pause(atq_pkg::CMD_PUSH, ALL_WORKERS, $urandom);
    send_and_pause(atq_pkg::CMD_PUSH, 64'h0, $urandom);
    send_and_pause(atq_pkg::CMD_POP, 64'd1 << 40, $urandom);
    send_and_pause(atq_pkg::CMD_POP, 64'h0, $urandom);
    while (shadow_count > 0)
      send_and_pause(atq_pkg::CMD_POP, ALL_WORKERS, $urandom);
  endtask

  // Random mix whose push share drifts so the store swings between empty and full.
  task automatic test_random_traffic();
    int push_pct;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        push_pct   = 30 + 20 * $urandom_range(0, 2);
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < push_pct)
        send_and_pause(atq_pkg::CMD_PUSH, random_task_mask(), $urandom);
      else
        send_and_pause(atq_pkg::CMD_POP, random_worker_mask(), $urandom);
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    request      = '0;
    shadow_count = 0;
    error_count  = 0;
    cycle_count  = 0;
    burst_mode   = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_store();
    test_random_traffic();

    // Let the last result arrive, then allow stray strobes to show up.
    start <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/atq_pkg.sv
hdl/affinity_task_queue.sv
hdl/atq_checker.sv
test/affinity_task_queue_tb.sv
